// ===== sv/tsm_pkg.sv =====
// Shared constants and the 2^(-j/16) table for the temperature softmax block.
package tsm_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;

    localparam int SCORE_W = 24;
    localparam int TEMP_W  = 16;
    localparam int PROB_W  = 17;
    localparam int INDEX_W = 6;
    localparam int SUM_W   = 24;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [TEMP_W-1:0] TEMP_RESET = 16'd256;
    localparam logic [16:0]       LOG2E_Q16  = 17'd94548;
    localparam logic [16:0]       ONE_Q16    = 17'd65536;
    localparam logic [SCORE_W-1:0] SCORE_MIN = 24'h800000;

    // 2^(-j/16) in Q.16, j = 0..16
    function automatic logic [16:0] pow2_neg(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/temperature_softmax.sv =====
// Temperature softmax top level: loader, sequencer, shared divider and output register.
//
// Scores stream in one per transfer (signed Q8.16, with a mask flag and a
// last-element mark) and are written into a local score memory while the
// running maximum of the unmasked entries is tracked. A transfer with last_in
// set starts the evaluation, and in_stall stays high until every probability
// of the run has been delivered. Evaluation is two passes over the stored
// elements, both built around one shared restoring divider that retires one
// quotient bit per cycle over a 33-bit numerator. Pass one, per element:
// memory read, operand setup, scaled distance / temperature, log2(e)
// multiply, table interpolation and shift. Pass two, per element: memory
// read, setup, normalizing division, then the output register, which holds
// the result until out_stall is low. A one-element run skips the divisions
// of pass two. Elements past MAX_ELEMENTS are dropped and reported on the
// overflow output of every result of that run. A temperature of 0 is treated
// as raw code 1, the smallest nonzero temperature. The temperature register
// is decoded on paddr[2] alone, so it sits at byte addresses 0 to 3 of the
// APB port; writes to addresses 4 to 7 are ignored.
module temperature_softmax
    import tsm_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SCORE_W-1:0]  log_prob,
    input  logic                masked,
    input  logic                last_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PROB_W-1:0]   probability,
    output logic [INDEX_W-1:0]  element_index,
    output logic                overflow,
    output logic                last_out
);

    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int NUM_W = 33;
    localparam logic [5:0] DIV_STEPS = 6'(NUM_W);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD1  = 4'd1;
    localparam logic [3:0] S_LD1  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_EXP  = 4'd5;
    localparam logic [3:0] S_RD2  = 4'd6;
    localparam logic [3:0] S_LD2  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    // ---------------- configuration ----------------
    logic [TEMP_W-1:0] temp_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? DATA_W'(temp_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg <= TEMP_RESET;
        end
        else if (cfg_wr)
        begin
            temp_reg <= pwdata[TEMP_W-1:0];
        end
    end

    // ---------------- memories ----------------
    logic [SCORE_W-1:0] score_mem [MAX_ELEMENTS];
    logic               mask_mem  [MAX_ELEMENTS];
    logic [PROB_W-1:0]  exp_mem   [MAX_ELEMENTS];
    logic [SCORE_W-1:0] score_rd_reg;
    logic               mask_rd_reg;
    logic [PROB_W-1:0]  exp_rd_reg;

    // ---------------- control and datapath state ----------------
    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [SCORE_W-1:0] max_reg, max_next;
    logic               any_reg, any_next;
    logic               ovf_reg, ovf_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               pass2_reg, pass2_next;
    logic [21:0]        z_reg, z_next;
    logic               big_reg, big_next;
    logic [NUM_W-1:0]   dq_reg, dq_next;
    logic [SUM_W-1:0]   dr_reg, dr_next;
    logic [SUM_W-1:0]   dd_reg, dd_next;
    logic [5:0]         dcnt_reg, dcnt_next;
    logic               ov_reg, ov_next;
    logic [PROB_W-1:0]  prob_reg, prob_next;

    logic               accept;
    logic               store_en;
    logic               exp_wr;
    logic [PROB_W-1:0]  e_val;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign store_en = accept && (count_reg < MAX_CNT);

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            score_mem[count_reg[IW-1:0]] <= log_prob;
            mask_mem[count_reg[IW-1:0]]  <= masked;
        end
        if (state_reg == S_RD1)
        begin
            score_rd_reg <= score_mem[idx_reg[IW-1:0]];
            mask_rd_reg  <= mask_mem[idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_wr)
        begin
            exp_mem[idx_reg[IW-1:0]] <= e_val;
        end
        if (state_reg == S_RD2)
        begin
            exp_rd_reg <= exp_mem[idx_reg[IW-1:0]];
        end
    end

    // ---------------- arithmetic helpers ----------------
    logic [TEMP_W-1:0]  temp_eff;
    logic [SCORE_W-1:0] score_gap;
    logic [25:0]        trial;
    logic               trial_ge;
    logic [37:0]        zprod;
    logic [5:0]         k_val;
    logic [3:0]         f_hi;
    logic [11:0]        f_lo;
    logic [16:0]        tab_hi, tab_lo;
    logic [11:0]        tab_diff;
    logic [23:0]        interp;
    logic [16:0]        v_val;
    logic [16:0]        v_sh;
    logic [16:0]        v_rnd;
    logic [CW-1:0]      n_plus;

    assign temp_eff  = (temp_reg == '0) ? TEMP_W'(1) : temp_reg;
    assign score_gap = max_reg - score_rd_reg;

    // one restoring step: shift in numerator MSB, try the subtract
    assign trial    = {1'b0, dr_reg, dq_reg[NUM_W-1]} - {2'b00, dd_reg};
    assign trial_ge = !trial[25];

    // low 21 bits of t (larger t is flagged by big_reg) times log2(e), rounded back to Q.16
    assign zprod = dq_reg[20:0] * LOG2E_Q16;

    assign k_val    = z_reg[21:16];
    assign f_hi     = z_reg[15:12];
    assign f_lo     = z_reg[11:0];
    assign tab_hi   = pow2_neg({1'b0, f_hi});
    assign tab_lo   = pow2_neg(5'({1'b0, f_hi}) + 5'd1);
    assign tab_diff = 12'(tab_hi - tab_lo);
    assign interp   = tab_diff * f_lo + 24'd2048;
    assign v_val    = tab_hi - 17'(interp[23:12]);
    assign v_sh     = v_val >> (k_val - 6'd1);
    assign v_rnd    = 17'((18'(v_sh) + 18'd1) >> 1);

    always_comb
    begin
        if (mask_rd_reg || big_reg || (k_val > 6'd16))
        begin
            e_val = '0;
        end
        else if (k_val == 6'd0)
        begin
            e_val = v_val;
        end
        else
        begin
            e_val = v_rnd;
        end
    end

    assign exp_wr = (state_reg == S_EXP);
    assign n_plus = count_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        max_next   = max_reg;
        any_next   = any_reg;
        ovf_next   = ovf_reg;
        sum_next   = sum_reg;
        pass2_next = pass2_reg;
        z_next     = z_reg;
        big_next   = big_reg;
        dq_next    = dq_reg;
        dr_next    = dr_reg;
        dd_next    = dd_reg;
        dcnt_next  = dcnt_reg;
        ov_next    = ov_reg;
        prob_next  = prob_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (store_en)
                    begin
                        count_next = count_reg + CW'(1);
                        if (!masked)
                        begin
                            if (!any_reg || ($signed(log_prob) > $signed(max_reg)))
                            begin
                                max_next = log_prob;
                            end
                            any_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        idx_next   = '0;
                        sum_next   = '0;
                        pass2_next = 1'b0;
                        state_next = S_RD1;
                    end
                end
            end

            S_RD1:
            begin
                state_next = S_LD1;
            end

            S_LD1:
            begin
                dq_next    = {1'b0, score_gap, 8'd0} + NUM_W'(temp_eff >> 1);
                dr_next    = '0;
                dd_next    = SUM_W'(temp_eff);
                dcnt_next  = DIV_STEPS;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                dq_next   = {dq_reg[NUM_W-2:0], trial_ge};
                dr_next   = trial_ge ? trial[SUM_W-1:0]
                                     : {dr_reg[SUM_W-2:0], dq_reg[NUM_W-1]};
                dcnt_next = dcnt_reg - 6'd1;
                if (dcnt_reg == 6'd1)
                begin
                    if (pass2_reg)
                    begin
                        prob_next  = PROB_W'({dq_reg[NUM_W-2:0], trial_ge});
                        ov_next    = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                big_next   = |dq_reg[NUM_W-1:21];
                z_next     = 22'((zprod + 38'd32768) >> 16);
                state_next = S_EXP;
            end

            S_EXP:
            begin
                sum_next = sum_reg + SUM_W'(e_val);
                idx_next = idx_reg + CW'(1);
                if ((idx_reg + CW'(1)) == count_reg)
                begin
                    idx_next   = '0;
                    pass2_next = 1'b1;
                    state_next = S_RD2;
                end
                else
                begin
                    state_next = S_RD1;
                end
            end

            S_RD2:
            begin
                state_next = S_LD2;
            end

            S_LD2:
            begin
                dr_next   = '0;
                dcnt_next = DIV_STEPS;
                if (count_reg == CW'(1))
                begin
                    prob_next  = ONE_Q16;
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
                else if (!any_reg || (sum_reg == '0))
                begin
                    dq_next    = NUM_W'(ONE_Q16) + NUM_W'(n_plus >> 1);
                    dd_next    = SUM_W'(count_reg);
                    state_next = S_DIV;
                end
                else
                begin
                    dq_next    = {exp_rd_reg, 16'd0} + NUM_W'(sum_reg >> 1);
                    dd_next    = sum_reg;
                    state_next = S_DIV;
                end
            end

            S_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    if ((idx_reg + CW'(1)) == count_reg)
                    begin
                        count_next = '0;
                        idx_next   = '0;
                        max_next   = SCORE_MIN;
                        any_next   = 1'b0;
                        ovf_next   = 1'b0;
                        sum_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_RD2;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            max_reg   <= SCORE_MIN;
            any_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            sum_reg   <= '0;
            pass2_reg <= 1'b0;
            dcnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            max_reg   <= max_next;
            any_reg   <= any_next;
            ovf_reg   <= ovf_next;
            sum_reg   <= sum_next;
            pass2_reg <= pass2_next;
            dcnt_reg  <= dcnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg    <= z_next;
        big_reg  <= big_next;
        dq_reg   <= dq_next;
        dr_reg   <= dr_next;
        dd_reg   <= dd_next;
        prob_reg <= prob_next;
    end

    // ---------------- result port ----------------
    assign out_valid     = ov_reg;
    assign probability   = prob_reg;
    assign element_index = INDEX_W'(idx_reg);
    assign overflow      = ovf_reg;
    assign last_out      = (idx_reg + CW'(1)) == count_reg;

endmodule

// ===== sv/tsm_checker.sv =====
// Port-level checker for the temperature softmax block, with its bind.
module tsm_checker
    import tsm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [PROB_W-1:0]  probability,
    input logic [INDEX_W-1:0] element_index,
    input logic               last_out
);

    // a waiting result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(probability)
            && $stable(element_index))
        else $error("result changed while stalled");

    // no new scores are taken while results are pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during result delivery");

    // after a non-final transfer the next result needs a fresh computation
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_out |=> !out_valid)
        else $error("results issued back to back");

    // probability never exceeds 1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> probability <= ONE_Q16)
        else $error("probability above one");

endmodule

bind temperature_softmax tsm_checker u_tsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .probability   (probability),
    .element_index (element_index),
    .last_out      (last_out)
);
